[rtl/core/lru_pr_pkg.sv]
// Shared types and constants for the LRU page replacement block.
`default_nettype none

package lru_pr_pkg;

    localparam int PROC_W    = 5;
    localparam int PC_W      = 12;
    localparam int MAP_W     = 32;
    localparam int MAP_EXT_W = 64;
    localparam int MAP_IDX_W = 6;
    localparam int PAGE_W    = 5;
    localparam int TIME_W    = 32;
    localparam int ACT_W     = 2;

    localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PAGE_IN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PAGE_OUT = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic calc_page;
        logic eval;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_scan;
        logic scan_last;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/core/lru_pr_ctrl.sv]
// Controller state machine: clearing pass, item sequencing and timestamp scan.
`default_nettype none

module lru_pr_ctrl
    import lru_pr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_strobe
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_PAGE   = 7'b0000100,
        S_EVAL   = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_PAGE;
                end
            end
            S_PAGE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.need_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.clr_step  = (r_state == S_CLEAR);
        o_cmd.load      = (r_state == S_IDLE) && i_start;
        o_cmd.calc_page = (r_state == S_PAGE);
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.scan      = (r_state == S_SCAN);
        o_cmd.finish    = (r_state == S_FINISH);
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_FINISH);

endmodule

`default_nettype wire

[rtl/core/lru_pr_dp.sv]
// Datapath: page decode, timestamp memory, oldest-page search and round clock.
`default_nettype none

module lru_pr_dp
    import lru_pr_pkg::*;
#(
    parameter int NUM_PROCESSES     = 32,
    parameter int PAGES_PER_PROCESS = 32,
    parameter int PAGE_BYTES        = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [PROC_W-1:0] i_process_index,
    input  wire logic              i_process_active,
    input  wire logic [PC_W-1:0]   i_program_counter,
    input  wire logic [MAP_W-1:0]  i_resident_map,
    input  wire logic              i_frame_free,
    input  wire logic              i_round_end,
    output t_dp_sts                o_sts,
    output logic [ACT_W-1:0]       o_action,
    output logic [PAGE_W-1:0]      o_target_page,
    output logic [PROC_W-1:0]      o_target_process
);

    localparam int DEPTH     = NUM_PROCESSES * PAGES_PER_PROCESS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW        = $clog2(PAGES_PER_PROCESS);
    // page = (pc * DIV_MUL) >> DIV_SHIFT, exact for every 12-bit pc
    localparam int DIV_SHIFT = PC_W + $clog2(PAGE_BYTES);
    localparam int DIV_MUL   = ((2 ** DIV_SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES;

    logic [PROC_W-1:0] r_proc;
    logic              r_active;
    logic [PC_W-1:0]   r_pc;
    logic [MAP_W-1:0]  r_map;
    logic              r_free;
    logic              r_last;

    logic [PC_W-1:0]   r_page;
    logic [AW-1:0]     r_base;
    logic              r_pvalid;
    logic              r_valid;

    logic [TIME_W-1:0] r_clock;
    logic [AW-1:0]     r_clr;
    logic [PW-1:0]     r_idx;
    logic              r_cmp_vld;
    logic [PW-1:0]     r_cmp_idx;
    logic [TIME_W-1:0] r_oldest;
    logic [TIME_W-1:0] r_rd_data;

    logic [ACT_W-1:0]  r_action;
    logic [PAGE_W-1:0] r_tpage;
    logic [PROC_W-1:0] r_tproc;

    logic [TIME_W-1:0] mem [DEPTH];

    logic [31:0]          w_prod;
    logic                 w_valid;
    logic [PW-1:0]        w_pidx;
    logic [MAP_EXT_W-1:0] w_map_ext;
    logic                 w_cur_res;
    logic                 w_cmp_res;
    logic [AW-1:0]        w_cur_addr;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_we;
    logic [AW-1:0]        w_wa;
    logic [TIME_W-1:0]    w_wd;

    assign w_prod     = 32'(r_pc) * 32'(DIV_MUL);
    assign w_valid    = r_pvalid && (32'(r_page) < 32'(PAGES_PER_PROCESS));
    assign w_pidx     = r_page[PW-1:0];
    assign w_map_ext  = {32'b0, r_map};
    assign w_cur_res  = w_map_ext[MAP_IDX_W'(w_pidx)];
    assign w_cmp_res  = w_map_ext[MAP_IDX_W'(r_cmp_idx)];
    assign w_cur_addr = r_base + AW'(w_pidx);
    assign w_rd_addr  = r_base + AW'(r_idx);

    assign w_we = i_cmd.clr_step || (i_cmd.finish && r_valid);
    assign w_wa = i_cmd.clr_step ? r_clr : w_cur_addr;
    assign w_wd = i_cmd.clr_step ? '0 : r_clock;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_proc   <= i_process_index;
            r_active <= i_process_active;
            r_pc     <= i_program_counter;
            r_map    <= i_resident_map;
            r_free   <= i_frame_free;
            r_last   <= i_round_end;
        end
        if (i_cmd.calc_page) begin
            r_page   <= PC_W'(w_prod >> DIV_SHIFT);
            r_base   <= AW'(32'(r_proc) * 32'(PAGES_PER_PROCESS));
            r_pvalid <= r_active && (32'(r_proc) < 32'(NUM_PROCESSES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock   <= TIME_W'(1);
            r_clr     <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.eval) begin
                r_valid <= w_valid;
                r_idx   <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + PW'(1);
            end
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.finish && r_last && (r_clock != '1)) begin
                r_clock <= r_clock + TIME_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_cmp_idx <= r_idx;
        end
        if (i_cmd.eval) begin
            r_oldest <= r_clock;
            if (!w_valid || w_cur_res) begin
                r_action <= ACT_NONE;
                r_tpage  <= '0;
                r_tproc  <= '0;
            end else if (r_free) begin
                r_action <= ACT_PAGE_IN;
                r_tpage  <= PAGE_W'(w_pidx);
                r_tproc  <= r_proc;
            end else begin
                r_action <= ACT_PAGE_OUT;
                r_tpage  <= PAGE_W'(w_pidx);
                r_tproc  <= r_proc;
            end
        end else if (r_cmp_vld && w_cmp_res && (r_rd_data < r_oldest)) begin
            r_oldest <= r_rd_data;
            r_tpage  <= PAGE_W'(r_cmp_idx);
        end
    end

    assign o_sts.clr_last  = (r_clr == AW'(DEPTH - 1));
    assign o_sts.need_scan = w_valid && !w_cur_res && !r_free;
    assign o_sts.scan_last = (r_idx == PW'(PAGES_PER_PROCESS - 1));

    assign o_action         = r_action;
    assign o_target_page    = r_tpage;
    assign o_target_process = r_tproc;

endmodule

`default_nettype wire

[rtl/core/lru_page_replacement.sv]
// Top level of the LRU page replacement block.
`default_nettype none

// One item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_strobe high, and it cannot be held off.
// After reset the block runs a clearing pass that zeroes all
// NUM_PROCESSES * PAGES_PER_PROCESS timestamps (1024 by default), with busy high.
// An item with no eviction search goes through the page, evaluate and finish
// states before the next item can be taken. An eviction adds a scan state that
// reads the process's stored timestamps one per cycle from the memory's read
// port, and a drain state before finish; busy stays high until the result is
// shown, so no new item is taken while one is in progress.
module lru_page_replacement
    import lru_pr_pkg::*;
#(
    parameter int NUM_PROCESSES     = 32,
    parameter int PAGES_PER_PROCESS = 32,
    parameter int PAGE_BYTES        = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [PROC_W-1:0] i_process_index,
    input  wire logic              i_process_active,
    input  wire logic [PC_W-1:0]   i_program_counter,
    input  wire logic [MAP_W-1:0]  i_resident_map,
    input  wire logic              i_frame_free,
    input  wire logic              i_round_end,
    output logic                   o_strobe,
    output logic [ACT_W-1:0]       o_action,
    output logic [PAGE_W-1:0]      o_target_page,
    output logic [PROC_W-1:0]      o_target_process
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lru_pr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    lru_pr_dp #(
        .NUM_PROCESSES     (NUM_PROCESSES),
        .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
        .PAGE_BYTES        (PAGE_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_process_index   (i_process_index),
        .i_process_active  (i_process_active),
        .i_program_counter (i_program_counter),
        .i_resident_map    (i_resident_map),
        .i_frame_free      (i_frame_free),
        .i_round_end       (i_round_end),
        .o_sts             (w_sts),
        .o_action          (o_action),
        .o_target_page     (o_target_page),
        .o_target_process  (o_target_process)
    );

    // accepted transfer always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    // one result per item
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_action == ACT_NONE) |->
            (o_target_page == '0) && (o_target_process == '0))
        else $error("no-action result carries nonzero targets");

    a_scan_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan && w_sts.scan_last |=> ##1 o_strobe && (o_action == ACT_PAGE_OUT))
        else $error("eviction search did not end in a page-out result");

endmodule

`default_nettype wire

[tb/sv/tb_lru_page_replacement.sv]
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 100ps

module tb_lru_page_replacement;
    import lru_pr_pkg::*;

    localparam int N_PROC      = 32;
    localparam int N_PAGE      = 32;
    localparam int PAGE_SIZE   = 128;
    localparam int N_ACTIVE    = 620;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [PROC_W-1:0] process_index;
        logic              process_active;
        logic [PC_W-1:0]   program_counter;
        logic [MAP_W-1:0]  resident_map;
        logic              frame_free;
        logic              round_end;
        logic              drain_first;
    } t_sched_entry;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] target_page;
        logic [PROC_W-1:0] target_process;
    } t_page_action;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [PROC_W-1:0] i_process_index = '0;
    logic              i_process_active = 1'b0;
    logic [PC_W-1:0]   i_program_counter = '0;
    logic [MAP_W-1:0]  i_resident_map = '0;
    logic              i_frame_free = 1'b0;
    logic              i_round_end = 1'b0;
    logic              o_strobe;
    logic [ACT_W-1:0]  o_action;
    logic [PAGE_W-1:0] o_target_page;
    logic [PROC_W-1:0] o_target_process;

    t_sched_entry      sched_q[$];
    t_page_action      page_action_q[$];
    t_sched_entry      cur_entry;
    logic [TIME_W-1:0] use_time [N_PROC*N_PAGE];
    logic [TIME_W-1:0] round_tick = 1;
    int                err_cnt = 0;
    int                issued_cnt = 0;
    int                n_sched_total = 0;
    int                gap_left = 0;
    int                stall_cycles = 0;

    lru_page_replacement #(
        .NUM_PROCESSES     (N_PROC),
        .PAGES_PER_PROCESS (N_PAGE),
        .PAGE_BYTES        (PAGE_SIZE)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_process_index  (i_process_index),
        .i_process_active (i_process_active),
        .i_program_counter(i_program_counter),
        .i_resident_map   (i_resident_map),
        .i_frame_free     (i_frame_free),
        .i_round_end      (i_round_end),
        .o_strobe         (o_strobe),
        .o_action         (o_action),
        .o_target_page    (o_target_page),
        .o_target_process (o_target_process)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_page_action predict_lru_action(input t_sched_entry e);
        t_page_action      r;
        int                pg;
        int                base;
        logic [TIME_W-1:0] oldest;
        int                victim;
        r.action         = ACT_NONE;
        r.target_page    = '0;
        r.target_process = '0;
        pg = int'(e.program_counter) / PAGE_SIZE;
        if (e.process_active && int'(e.process_index) < N_PROC && pg < N_PAGE) begin
            base = int'(e.process_index) * N_PAGE;
            if (!(pg < MAP_W && e.resident_map[pg])) begin
                r.target_process = e.process_index;
                if (e.frame_free) begin
                    r.action      = ACT_PAGE_IN;
                    r.target_page = PAGE_W'(pg);
                end else begin
                    oldest = round_tick;
                    victim = pg;
                    for (int j = 0; j < N_PAGE; j++) begin
                        if (use_time[base+j] < oldest && j < MAP_W && e.resident_map[j]) begin
                            oldest = use_time[base+j];
                            victim = j;
                        end
                    end
                    r.action      = ACT_PAGE_OUT;
                    r.target_page = PAGE_W'(victim);
                end
            end
            use_time[base+pg] = round_tick;
        end
        if (e.round_end && round_tick != '1)
            round_tick = round_tick + 1;
        return r;
    endfunction

    task automatic add_sched(input int pidx, input bit act, input int pc,
                             input logic [MAP_W-1:0] map, input bit ff,
                             input bit rend, input bit drain);
        t_sched_entry e;
        e.process_index   = PROC_W'(pidx);
        e.process_active  = act;
        e.program_counter = PC_W'(pc);
        e.resident_map    = map;
        e.frame_free      = ff;
        e.round_end       = rend;
        e.drain_first     = drain;
        sched_q.push_back(e);
    endtask

    function automatic logic [MAP_W-1:0] pick_map(input int pg);
        logic [MAP_W-1:0] m;
        case ($urandom_range(0, 5))
            0: m = $urandom();
            1: m = $urandom() | $urandom();
            2: m = $urandom() & $urandom() & $urandom();
            3: m = '0;
            4: m = '1;
            default: m = ~($urandom() & $urandom());
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: m[pg] = 1'b0;
            6: m[pg] = 1'b1;
            default: ;
        endcase
        return m;
    endfunction

    // stimulus: directed cases, then rounds over a small set of hot processes
    initial begin : stimulus
        int hot [3];
        int n_active;
        int round_len;
        int pidx;
        int pc;
        bit act;
        bit drain;
        bit drain_done;

        for (int k = 0; k < N_PROC*N_PAGE; k++)
            use_time[k] = '0;

        add_sched(0,  1, 12'h000,        32'h0000_0000, 1, 0, 0);
        add_sched(31, 1, 12'hFFF,        32'hFFFF_FFFF, 0, 0, 0);
        add_sched(31, 0, 12'hFFF,        32'hFFFF_FFFF, 1, 1, 0);
        add_sched(31, 1, 12'hF80,        32'h7FFF_FFFF, 0, 0, 0);
        add_sched(5,  1, 3*PAGE_SIZE,    32'h0000_0008, 0, 0, 0);
        // nothing older than the current tick: victim is the current page
        add_sched(5,  1, 7*PAGE_SIZE+5,  32'h0000_0008, 0, 0, 0);
        add_sched(5,  1, 9*PAGE_SIZE,    32'h0000_0088, 0, 1, 0);
        // equal oldest times: lowest page wins
        add_sched(5,  1, 11*PAGE_SIZE,   32'h0000_0288, 0, 0, 0);
        add_sched(5,  1, 12*PAGE_SIZE,   32'h0000_0000, 0, 0, 0);
        add_sched(5,  1, 13*PAGE_SIZE,   32'hFFFF_DFFF, 1, 0, 0);
        add_sched(5,  1, 14*PAGE_SIZE-1, 32'hFFFF_DFFF, 0, 1, 0);
        add_sched(5,  0, 0,              32'h0000_0000, 0, 0, 0);
        add_sched(0,  1, 12'h07F,        32'hFFFF_FFFE, 0, 0, 0);
        add_sched(0,  1, 12'h080,        32'h0000_0001, 0, 1, 0);
        add_sched(17, 1, 12'hA55,        32'hAAAA_5555, 1, 0, 0);
        add_sched(10, 1, 12'h5AA,        32'h5555_AAAA, 0, 1, 0);

        n_active   = 0;
        drain      = 1'b1;
        drain_done = 1'b0;
        while (n_active < N_ACTIVE) begin
            if (n_active % 80 == 0)
                for (int h = 0; h < 3; h++)
                    hot[h] = $urandom_range(0, N_PROC-1);
            round_len = $urandom_range(1, 8);
            for (int k = 0; k < round_len; k++) begin
                act  = ($urandom_range(0, 9) != 0);
                pidx = ($urandom_range(0, 6) == 0) ? $urandom_range(0, N_PROC-1)
                                                   : hot[$urandom_range(0, 2)];
                pc   = $urandom_range(0, 4095);
                if (!drain_done && n_active >= N_ACTIVE/2) begin
                    drain      = 1'b1;
                    drain_done = 1'b1;
                end
                if (act)
                    add_sched(pidx, 1'b1, pc, pick_map(pc / PAGE_SIZE),
                              $urandom_range(0, 1), k == round_len-1, drain);
                else
                    add_sched(pidx, 1'b0, pc, $urandom(), $urandom_range(0, 1),
                              k == round_len-1, drain);
                drain = 1'b0;
                if (act)
                    n_active++;
            end
        end
        n_sched_total = sched_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sched_q.size() != 0 || start || page_action_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (page_action_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, page_action_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("[lru_page_replacement] OK");
        else
            $display("[lru_page_replacement] ERROR");
        $finish;
    end

    // driver: one transfer at a time, random idle bursts, none near the end
    always @(posedge i_clk) begin : driver
        bit took;
        bit may_idle;
        took = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (took)
                page_action_q.push_back(predict_lru_action(cur_entry));
            may_idle = (issued_cnt < n_sched_total - 150) && ((issued_cnt / 60) % 3 != 2);
            if (start && !took) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (sched_q.size() != 0 && sched_q[0].drain_first
                         && page_action_q.size() != 0) begin
                start <= 1'b0;
            end else if (sched_q.size() != 0) begin
                cur_entry = sched_q.pop_front();
                issued_cnt++;
                i_process_index   <= cur_entry.process_index;
                i_process_active  <= cur_entry.process_active;
                i_program_counter <= cur_entry.program_counter;
                i_resident_map    <= cur_entry.resident_map;
                i_frame_free      <= cur_entry.frame_free;
                i_round_end       <= cur_entry.round_end;
                start             <= 1'b1;
                if (may_idle && $urandom_range(0, 99) < 25)
                    gap_left = $urandom_range(1, 11);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results arrive in transfer order
    always @(posedge i_clk) begin : monitor
        t_page_action exp_r;
        if (i_rst_n && o_strobe) begin
            if (page_action_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual action=%0d page=%0d proc=%0d",
                         $time, o_action, o_target_page, o_target_process);
                err_cnt++;
            end else begin
                exp_r = page_action_q.pop_front();
                if (o_action !== exp_r.action) begin
                    $display("%0t: action mismatch: expected %0d actual %0d",
                             $time, exp_r.action, o_action);
                    err_cnt++;
                end
                if (o_target_page !== exp_r.target_page) begin
                    $display("%0t: target_page mismatch: expected %0d actual %0d",
                             $time, exp_r.target_page, o_target_page);
                    err_cnt++;
                end
                if (o_target_process !== exp_r.target_process) begin
                    $display("%0t: target_process mismatch: expected %0d actual %0d",
                             $time, exp_r.target_process, o_target_process);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: covers the clearing pass after reset with margin
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("[lru_page_replacement] ERROR");
                $finish;
            end
        end
    end

endmodule
